[rtl/hurst_pkg.sv]
// Shared constants, payload types and codes for the Hurst exponent estimator.
`timescale 1ns / 1ps

package hurst_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int MAX_LAGS    = 256;

	localparam int ADDR_W   = $clog2(MAX_SAMPLES);
	localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
	localparam int CFG_W    = 9;
	localparam int N_W      = $clog2(MAX_LAGS + 2);
	localparam int SAMPLE_W = 32;
	localparam int D_W      = SAMPLE_W + 1;
	localparam int SD_W     = D_W + ADDR_W;
	localparam int SQ_W     = 2 * SAMPLE_W + 1;
	localparam int S2_W     = SQ_W + ADDR_W;
	localparam int Q_W      = S2_W + CNT_W;
	localparam int FRAC_W   = 16;
	localparam int P_W      = $clog2(Q_W);
	localparam int LG_W     = P_W + FRAC_W;
	localparam int X_W      = LG_W;
	localparam int Y_W      = LG_W + 2;
	localparam int SX_W     = X_W + N_W;
	localparam int SY_W     = Y_W + N_W;
	localparam int SXX_W    = 2 * X_W + N_W;
	localparam int SXY_W    = X_W + Y_W + N_W;
	localparam int MUL_W    = D_W + 1;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int MANT_W   = 32;
	localparam int ACC_W    = Q_W + 6;
	localparam int MP_W     = SD_W;
	localparam int HURST_W  = 20;
	localparam int STATUS_W = 2;
	localparam int QT_W     = HURST_W + 1;
	localparam int IDX_W    = $clog2(QT_W);
	localparam int FIDX_W   = $clog2(FRAC_W);

	localparam logic [CFG_W-1:0] LAG_RESET = CFG_W'(98);

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROP = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} req_t;

	typedef struct packed {
		logic signed [HURST_W-1:0] hurst;
		logic [STATUS_W-1:0]       status;
	} res_t;

endpackage

[rtl/hurst_exponent_estimator.sv]
// Hurst exponent estimator: sample store, lag sweep, shared-unit fit and divide.
// Load: one sample per cycle while idle, ready again the next cycle after a plain sample.
// The estimate after last is set by the sweep of the store through the two RAM
// read ports plus the shift-add multiply and log normalization loops for every lag.
// Reset (arst_n low, asynchronous) empties the store count, clears the
// dropped flag and the result valid flag and sets lag_count to 98; store contents stay.
`timescale 1ns / 1ps

module hurst_exponent_estimator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  hurst_pkg::req_t                 req_data,
	output logic                            res_valid,
	input  logic                            res_ready,
	output hurst_pkg::res_t                 res_data,
	input  logic                            cfg_we,
	input  logic [hurst_pkg::CFG_W-1:0]     cfg_wdata
);
	import hurst_pkg::*;

	// sequencer codes
	localparam int STATE_W = 5;
	localparam logic [STATE_W-1:0] S_IDLE  = 5'd0;
	localparam logic [STATE_W-1:0] S_CHECK = 5'd1;
	localparam logic [STATE_W-1:0] S_LAG   = 5'd2;
	localparam logic [STATE_W-1:0] S_SWEEP = 5'd3;
	localparam logic [STATE_W-1:0] S_QJOB  = 5'd4;
	localparam logic [STATE_W-1:0] S_QJOB2 = 5'd5;
	localparam logic [STATE_W-1:0] S_SER   = 5'd6;
	localparam logic [STATE_W-1:0] S_QCHK  = 5'd7;
	localparam logic [STATE_W-1:0] S_LGN   = 5'd8;
	localparam logic [STATE_W-1:0] S_LGM   = 5'd9;
	localparam logic [STATE_W-1:0] S_LGC   = 5'd10;
	localparam logic [STATE_W-1:0] S_LGD   = 5'd11;
	localparam logic [STATE_W-1:0] S_ACC   = 5'd12;
	localparam logic [STATE_W-1:0] S_MXX   = 5'd13;
	localparam logic [STATE_W-1:0] S_AXX   = 5'd14;
	localparam logic [STATE_W-1:0] S_MXY   = 5'd15;
	localparam logic [STATE_W-1:0] S_AXY   = 5'd16;
	localparam logic [STATE_W-1:0] S_FIT   = 5'd17;
	localparam logic [STATE_W-1:0] S_FIT1  = 5'd18;
	localparam logic [STATE_W-1:0] S_FIT2  = 5'd19;
	localparam logic [STATE_W-1:0] S_FIT3  = 5'd20;
	localparam logic [STATE_W-1:0] S_DIVS  = 5'd21;
	localparam logic [STATE_W-1:0] S_DIV   = 5'd22;
	localparam logic [STATE_W-1:0] S_SAT   = 5'd23;
	localparam logic [STATE_W-1:0] S_OUT   = 5'd24;

	// which value the log unit is working on
	localparam logic [1:0] LG_Q  = 2'd0;
	localparam logic [1:0] LG_M  = 2'd1;
	localparam logic [1:0] LG_M1 = 2'd2;
	localparam logic [1:0] LG_L  = 2'd3;

	localparam logic [QT_W-1:0] Q_POS_MAX = QT_W'((1 << (HURST_W - 1)) - 1);
	localparam logic [QT_W-1:0] Q_NEG_MAX = QT_W'(1 << (HURST_W - 1));

	// control
	logic [CFG_W-1:0]   lag_q;
	logic [STATE_W-1:0] state_q, ret_q;
	logic [CNT_W-1:0]   count_q, m_q, k_q;
	logic               ovf_q;
	logic [N_W-1:0]     n_q, l_q, n_c;
	logic               rd_v_q, d_v_q, p_v_q;
	logic [IDX_W-1:0]   bit_q;
	logic [1:0]         lsel_q;
	logic               res_valid_q;

	// datapath
	logic signed [D_W-1:0]    d_q;
	logic signed [PROD_W-1:0] prod_q, prod_c;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [SD_W-1:0]   sd_q;
	logic [SD_W-1:0]          sd_abs;
	logic [S2_W-1:0]          s2_q;
	logic signed [ACC_W-1:0]  acc_q, b_q;
	logic [ACC_W-1:0]         mcand_q;
	logic [MP_W-1:0]          mplier_q;
	logic                     sub_q, neg_q;
	logic [Q_W-1:0]           lgv_q;
	logic [P_W-1:0]           p_q;
	logic [MANT_W-1:0]        mant_q;
	logic [MANT_W:0]          sq_top;
	logic [FRAC_W-1:0]        frac_q;
	logic [LG_W-1:0]          lg_val;
	logic signed [Y_W-1:0]    y_q;
	logic [X_W-1:0]           x_q;
	logic [SX_W-1:0]          sx_q;
	logic signed [SY_W-1:0]   sy_q;
	logic [SY_W-1:0]          sy_abs;
	logic [SXX_W-1:0]         sxx_q;
	logic signed [SXY_W-1:0]  sxy_q;
	logic [SXY_W-1:0]         sxy_abs;
	logic [QT_W-1:0]          qt_q;
	logic signed [HURST_W-1:0] hur_q;
	logic [STATUS_W-1:0]      st_q;
	res_t                     res_q;

	// store
	logic                     req_xfer, st_we, sweep_issue, sweep_done;
	logic [ADDR_W-1:0]        ra_addr, rb_addr;
	logic [SAMPLE_W-1:0]      ra_data, rb_data;

	assign req_ready = (state_q == S_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign st_we     = req_xfer && (count_q < CNT_W'(MAX_SAMPLES));
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// sweep issues x[k+L] and x[k] together
	assign sweep_issue = (state_q == S_SWEEP) && (k_q != m_q);
	assign sweep_done  = (k_q == m_q) && !rd_v_q && !d_v_q && !p_v_q;
	assign ra_addr     = ADDR_W'(k_q + CNT_W'(l_q));
	assign rb_addr     = k_q[ADDR_W-1:0];

	hurst_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk    (clk),
		.we     (st_we),
		.waddr  (count_q[ADDR_W-1:0]),
		.wdata  (req_data.sample),
		.ra_addr(ra_addr),
		.ra_data(ra_data),
		.rb_addr(rb_addr),
		.rb_data(rb_data)
	);

	// effective lag count, clamped
	always_comb begin
		if (int'(lag_q) < 2) begin
			n_c = N_W'(2);
		end else if (int'(lag_q) > MAX_LAGS) begin
			n_c = N_W'(MAX_LAGS);
		end else begin
			n_c = N_W'(lag_q);
		end
	end

	// the one combinational multiplier: d^2 in the sweep, mantissa squaring, x*x and x*y
	always_comb begin
		if (state_q == S_LGM) begin
			mul_a = MUL_W'(mant_q);
			mul_b = MUL_W'(mant_q);
		end else if (state_q == S_MXX) begin
			mul_a = MUL_W'(x_q);
			mul_b = MUL_W'(x_q);
		end else if (state_q == S_MXY) begin
			mul_a = MUL_W'(x_q);
			mul_b = MUL_W'(y_q);
		end else begin
			mul_a = MUL_W'(d_q);
			mul_b = MUL_W'(d_q);
		end
	end
	assign prod_c = mul_a * mul_b;

	assign sd_abs  = sd_q[SD_W-1] ? SD_W'(-sd_q) : SD_W'(sd_q);
	assign sy_abs  = sy_q[SY_W-1] ? SY_W'(-sy_q) : SY_W'(sy_q);
	assign sxy_abs = sxy_q[SXY_W-1] ? SXY_W'(-sxy_q) : SXY_W'(sxy_q);
	assign sq_top  = prod_q[2*MANT_W-1:MANT_W-1];
	assign lg_val  = {p_q, frac_q};

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q       <= LAG_RESET;
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			n_q         <= '0;
			l_q         <= '0;
			m_q         <= '0;
			k_q         <= '0;
			rd_v_q      <= 1'b0;
			d_v_q       <= 1'b0;
			p_v_q       <= 1'b0;
			bit_q       <= '0;
			lsel_q      <= LG_Q;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lag_q <= cfg_wdata;
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			rd_v_q <= sweep_issue;
			d_v_q  <= rd_v_q;
			p_v_q  <= d_v_q;
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						if (st_we) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						n_q <= n_c;
						if (req_data.last) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					l_q <= N_W'(2);
					if ((CNT_W + 1)'(count_q) < (CNT_W + 1)'(n_q) + (CNT_W + 1)'(3)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_LAG;
					end
				end
				S_LAG: begin
					m_q     <= count_q - CNT_W'(l_q);
					k_q     <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (sweep_issue) begin
						k_q <= k_q + 1'b1;
					end
					if (sweep_done) begin
						state_q <= S_QJOB;
					end
				end
				S_QJOB: begin
					ret_q   <= S_QJOB2;
					state_q <= S_SER;
				end
				S_QJOB2: begin
					ret_q   <= S_QCHK;
					state_q <= S_SER;
				end
				S_SER: begin
					if (mplier_q == '0) begin
						state_q <= ret_q;
					end
				end
				S_QCHK: begin
					lsel_q <= LG_Q;
					if (acc_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_LGN;
					end
				end
				S_LGN: begin
					if (lgv_q[Q_W-1]) begin
						bit_q   <= IDX_W'(FRAC_W - 1);
						state_q <= S_LGM;
					end
				end
				S_LGM: begin
					state_q <= S_LGC;
				end
				S_LGC: begin
					if (bit_q == '0) begin
						state_q <= S_LGD;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= S_LGM;
					end
				end
				S_LGD: begin
					unique case (lsel_q)
						LG_Q: begin
							lsel_q  <= LG_M;
							state_q <= S_LGN;
						end
						LG_M: begin
							lsel_q  <= LG_M1;
							state_q <= S_LGN;
						end
						LG_M1: begin
							lsel_q  <= LG_L;
							state_q <= S_LGN;
						end
						default: begin
							state_q <= S_ACC;
						end
					endcase
				end
				S_ACC: state_q <= S_MXX;
				S_MXX: state_q <= S_AXX;
				S_AXX: state_q <= S_MXY;
				S_MXY: state_q <= S_AXY;
				S_AXY: begin
					if (l_q == n_q + N_W'(1)) begin
						state_q <= S_FIT;
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= S_LAG;
					end
				end
				S_FIT: begin
					ret_q   <= S_FIT1;
					state_q <= S_SER;
				end
				S_FIT1: begin
					ret_q   <= S_FIT2;
					state_q <= S_SER;
				end
				S_FIT2: begin
					ret_q   <= S_FIT3;
					state_q <= S_SER;
				end
				S_FIT3: begin
					ret_q   <= S_DIVS;
					state_q <= S_SER;
				end
				S_DIVS: begin
					bit_q <= IDX_W'(QT_W - 1);
					if (b_q[ACC_W-1] || (b_q == '0)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_SAT;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_SAT: state_q <= S_OUT;
				S_OUT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						count_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		// lagged difference pipeline: read, subtract, square, accumulate
		if (rd_v_q) begin
			d_q <= $signed({ra_data[SAMPLE_W-1], ra_data})
				- $signed({rb_data[SAMPLE_W-1], rb_data});
		end
		if (d_v_q) begin
			sd_q <= sd_q + SD_W'(d_q);
		end
		if (p_v_q) begin
			s2_q <= s2_q + S2_W'(prod_q[SQ_W-1:0]);
		end
		unique case (state_q)
			S_CHECK: begin
				sx_q  <= '0;
				sy_q  <= '0;
				sxx_q <= '0;
				sxy_q <= '0;
				hur_q <= '0;
				st_q  <= ST_FEW;
			end
			S_LAG: begin
				sd_q <= '0;
				s2_q <= '0;
			end
			S_QJOB: begin
				// Q = m * sum(d^2) - (sum d)^2
				acc_q    <= '0;
				mcand_q  <= ACC_W'(s2_q);
				mplier_q <= MP_W'(m_q);
				sub_q    <= 1'b0;
			end
			S_QJOB2: begin
				mcand_q  <= ACC_W'(sd_abs);
				mplier_q <= MP_W'(sd_abs);
				sub_q    <= 1'b1;
			end
			S_SER: begin
				if (mplier_q != '0) begin
					if (mplier_q[0]) begin
						acc_q <= sub_q ? acc_q - $signed(mcand_q) : acc_q + $signed(mcand_q);
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			S_QCHK: begin
				hur_q  <= '0;
				st_q   <= ST_ZERO;
				lgv_q  <= acc_q[Q_W-1:0];
				p_q    <= P_W'(Q_W - 1);
				frac_q <= '0;
			end
			S_LGN: begin
				if (lgv_q[Q_W-1]) begin
					mant_q <= lgv_q[Q_W-1 -: MANT_W];
				end else begin
					lgv_q <= lgv_q << 1;
					p_q   <= p_q - 1'b1;
				end
			end
			S_LGC: begin
				// each squaring yields one fraction bit
				if (sq_top[MANT_W]) begin
					mant_q                   <= sq_top[MANT_W:1];
					frac_q[bit_q[FIDX_W-1:0]] <= 1'b1;
				end else begin
					mant_q <= sq_top[MANT_W-1:0];
				end
			end
			S_LGD: begin
				p_q    <= P_W'(Q_W - 1);
				frac_q <= '0;
				unique case (lsel_q)
					LG_Q: begin
						y_q   <= Y_W'(lg_val);
						lgv_q <= Q_W'(m_q);
					end
					LG_M: begin
						y_q   <= y_q - Y_W'(lg_val);
						lgv_q <= Q_W'(m_q) - Q_W'(1);
					end
					LG_M1: begin
						y_q   <= y_q - Y_W'(lg_val);
						lgv_q <= Q_W'(l_q);
					end
					default: begin
						x_q <= X_W'(lg_val);
					end
				endcase
			end
			S_ACC: begin
				sx_q <= sx_q + SX_W'(x_q);
				sy_q <= sy_q + SY_W'(y_q);
			end
			S_AXX: sxx_q <= sxx_q + SXX_W'(prod_q[2*X_W-1:0]);
			S_AXY: sxy_q <= sxy_q + SXY_W'($signed(prod_q[X_W+Y_W-1:0]));
			S_FIT: begin
				// B = n*SXX - SX^2
				acc_q    <= '0;
				mcand_q  <= ACC_W'(sxx_q);
				mplier_q <= MP_W'(n_q);
				sub_q    <= 1'b0;
			end
			S_FIT1: begin
				mcand_q  <= ACC_W'(sx_q);
				mplier_q <= MP_W'(sx_q);
				sub_q    <= 1'b1;
			end
			S_FIT2: begin
				// A = n*SXY - SX*SY
				b_q      <= acc_q;
				acc_q    <= '0;
				mcand_q  <= ACC_W'(sxy_abs);
				mplier_q <= MP_W'(n_q);
				sub_q    <= sxy_q[SXY_W-1];
			end
			S_FIT3: begin
				mcand_q  <= ACC_W'(sy_abs);
				mplier_q <= MP_W'(sx_q);
				sub_q    <= ~sy_q[SY_W-1];
			end
			S_DIVS: begin
				hur_q   <= '0;
				st_q    <= ovf_q ? ST_DROP : ST_OK;
				neg_q   <= acc_q[ACC_W-1];
				acc_q   <= (acc_q[ACC_W-1] ? -acc_q : acc_q) << FRAC_W;
				mcand_q <= $unsigned(b_q) << QT_W;
				qt_q    <= '0;
			end
			S_DIV: begin
				// restoring divide of |A|*2^16 by 2B; top quotient bit means saturate
				if ($unsigned(acc_q) >= mcand_q) begin
					acc_q <= acc_q - $signed(mcand_q);
					qt_q  <= {qt_q[QT_W-2:0], 1'b1};
				end else begin
					qt_q <= {qt_q[QT_W-2:0], 1'b0};
				end
				mcand_q <= mcand_q >> 1;
			end
			S_SAT: begin
				if (neg_q) begin
					hur_q <= (qt_q > Q_NEG_MAX) ? $signed(HURST_W'(Q_NEG_MAX))
						: -$signed(qt_q[HURST_W-1:0]);
				end else begin
					hur_q <= (qt_q > Q_POS_MAX) ? $signed(HURST_W'(Q_POS_MAX))
						: $signed(qt_q[HURST_W-1:0]);
				end
			end
			S_OUT: begin
				if (!res_valid_q || res_ready) begin
					res_q.hurst  <= hur_q;
					res_q.status <= st_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/hurst_ram.sv]
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module hurst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	output logic [WIDTH-1:0]         ra_data,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

[rtl/hurst_checker.sv]
// Port-level checks for the Hurst exponent estimator, bound to the top level.
`timescale 1ns / 1ps

module hurst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input hurst_pkg::req_t             req_data,
	input logic                        res_valid,
	input logic                        res_ready,
	input hurst_pkg::res_t             res_data,
	input logic                        cfg_we,
	input logic [hurst_pkg::CFG_W-1:0] cfg_wdata
);
	import hurst_pkg::*;

	// a waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// the final sample starts the estimate, so intake stops
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.last |=> !req_ready)
		else $error("still ready after final sample");

	// plain samples only load the store
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_data.last |=> req_ready)
		else $error("not ready after plain sample");

	// error results carry a zero estimate
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == ST_FEW || res_data.status == ST_ZERO)
		|-> res_data.hurst == '0)
		else $error("nonzero estimate on error status");

endmodule

bind hurst_exponent_estimator hurst_checker u_hurst_checker (.*);
